// ----- hdl/pwl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_pkg
// shared types and codes of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned MaxCh   = 8;
  localparam int unsigned InDataW = 296;
  localparam int unsigned DivSteps = 64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNUSABLE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOSEG    = 2'd3
  } status_e;

  // where a query result comes from
  typedef enum logic [2:0] {
    RS_UNUSABLE = 3'd0,
    RS_FIRST    = 3'd1,
    RS_LAST     = 3'd2,
    RS_NOSEG    = 3'd3,
    RS_ROW      = 3'd4,
    RS_INTERP   = 3'd5
  } res_sel_e;

  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_HIT  = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic     accept;
    logic     scan_start;
    logic     scan_run;
    rd_sel_e  rd_sel;
    logic     cap_v0;
    logic     cap_v1;
    logic     mul;
    logic     div_step;
    logic     res_set;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic unusable;
    logic clamp_lo;
    logic clamp_hi;
    logic scan_done;
    logic scan_any;
    logic hit;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/piecewise_linear_table_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// flow: load, clear and unused op go from accept straight to the done state;
// a query that clamps or is refused passes the evaluation state only, otherwise
// it runs a linear scan over the n stored points at one table read a cycle,
// two row reads, one multiply and a 64-step bit-serial divider
// throughput: one item at a time; the next item is taken while a result waits
// reset clears the point count and channel flags at once, the stores are not swept
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// table of points with linear interpolation of one channel per query
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp
  import pwl_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // position [31:0], channel [34:32], value_ch0..value_ch7 from bit 35 up, zero pad
  input  wire [InDataW-1:0]   s_axis_tdata,
  // op [1:0]
  input  wire [1:0]           s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // result_value [31:0]
  output logic [ValW-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [1:0]          m_axis_tuser
);

  cmd_t    cmd;
  sts_t    sts;
  op_e     op;
  status_e out_status;

  assign op = op_e'(s_axis_tuser);

  pwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pwl_datapath #(
    .MAX_POINTS   (MAX_POINTS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op),
    .pos_i        (s_axis_tdata[31:0]),
    .ch_i         (s_axis_tdata[34:32]),
    .vals_i       (s_axis_tdata[35 +: NUM_CHANNELS*ValW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (out_status)
  );

  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

// ----- hdl/pwl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_ctrl
// sequencer: accepts an item, steps the datapath through search and divide
// ----------------------------------------------------------------------------
module pwl_ctrl
  import pwl_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  op_e  op_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EVAL  = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_READ0 = 10'b00_0000_1000,
    S_READ1 = 10'b00_0001_0000,
    S_WAIT1 = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_FIX   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = RD_SCAN;
    cmd_o.res_sel = RS_UNUSABLE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d = (op_i == OP_QUERY) ? S_EVAL : S_DONE;
        end
      end
      S_EVAL: begin
        if (sts_i.unusable) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_sel = RS_UNUSABLE;
          state_d = S_DONE;
        end else if (sts_i.clamp_lo) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_sel = RS_FIRST;
          state_d = S_DONE;
        end else if (sts_i.clamp_hi) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_sel = RS_LAST;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.scan_any) begin
            state_d = S_READ0;
          end else begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_sel = RS_NOSEG;
            state_d = S_DONE;
          end
        end
      end
      S_READ0: begin
        cmd_o.rd_sel = RD_HIT;
        state_d = S_READ1;
      end
      S_READ1: begin
        if (sts_i.hit) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_sel = RS_ROW;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_sel = RD_NEXT;
          cmd_o.cap_v0 = 1'b1;
          state_d = S_WAIT1;
        end
      end
      S_WAIT1: begin
        cmd_o.cap_v1 = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.res_set = 1'b1;
        cmd_o.res_sel = RS_INTERP;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  a_query_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_QUERY) |=> (state_q == S_EVAL))
    else $error("query item did not enter evaluation");

endmodule
`default_nettype wire

// ----- hdl/pwl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwl_datapath
// point tables, segment scan, multiplier, restoring divider, output register
// ----------------------------------------------------------------------------
module pwl_datapath
  import pwl_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  input  op_e                           op_i,
  input  wire [ValW-1:0]                pos_i,
  input  wire [2:0]                     ch_i,
  input  wire [NUM_CHANNELS*ValW-1:0]   vals_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [ValW-1:0]               out_value_o,
  output status_e                       out_status_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned RW  = NUM_CHANNELS * ValW;
  localparam int unsigned DCW = $clog2(DivSteps);

  logic [ValW-1:0] pos_mem [MAX_POINTS];
  logic [RW-1:0]   row_mem [MAX_POINTS];

  logic [CW-1:0]           count_q;
  logic [NUM_CHANNELS-1:0] varies_q;
  logic [RW-1:0]           first_row_q, last_row_q;
  logic [ValW-1:0]         first_pos_q, last_pos_q;
  logic [ValW-1:0]         x_q;
  logic [2:0]              ch_q;

  logic [AW-1:0]   rd_addr;
  logic [ValW-1:0] pos_rd_q;
  logic [RW-1:0]   row_rd_q;

  logic [CW-1:0]   issue_q;
  logic            rvalid_q;
  logic [AW-1:0]   ridx_q;
  logic [ValW-1:0] prev_q;
  logic            hit_q, seg_q;
  logic [AW-1:0]   hit_idx_q, seg_idx_q;
  logic [ValW-1:0] t_q, d_q;

  logic [ValW-1:0] v0_q, mag_q;
  logic            neg_q;
  logic [2*ValW-1:0] quo_q;
  logic [ValW-1:0] rem_q;
  logic [DCW-1:0]  dcnt_q;

  logic [ValW-1:0] res_q, out_value_q;
  status_e         res_st_q, out_status_q;
  logic            out_valid_q;

  logic full, load_wr, hit_now, seg_now, last_now;
  logic [AW-1:0] wr_addr;

  function automatic logic [ValW-1:0] pick(input logic [RW-1:0] row, input logic [2:0] ch);
    logic [ValW-1:0] r;
    r = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (3'(c) == ch) r = row[c*ValW +: ValW];
    end
    return r;
  endfunction

  assign full    = (count_q == CW'(MAX_POINTS));
  assign load_wr = cmd_i.accept && (op_i == OP_LOAD) && !full;
  assign wr_addr = count_q[AW-1:0];

  // query checks on the latched item
  logic ch_ok, varies_sel;
  always_comb begin
    varies_sel = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (3'(c) == ch_q) varies_sel = varies_q[c];
    end
  end
  assign ch_ok = ({1'b0, ch_q} < 4'(NUM_CHANNELS));

  assign sts_o.unusable = (count_q == '0) || !ch_ok || !varies_sel
                          || (pick(first_row_q, ch_q) != '0);
  assign sts_o.clamp_lo = (x_q <= first_pos_q);
  assign sts_o.clamp_hi = (x_q >= last_pos_q);

  // scan: one stored position per cycle, read data arrives the cycle after its address
  assign hit_now  = rvalid_q && (pos_rd_q == x_q);
  assign seg_now  = rvalid_q && (ridx_q != '0) && (prev_q <= x_q) && (x_q <= pos_rd_q);
  assign last_now = rvalid_q && (CW'(ridx_q) == count_q - CW'(1));
  assign sts_o.scan_done = cmd_i.scan_run && (hit_now || last_now);
  assign sts_o.scan_any  = hit_now || seg_now || seg_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.div_done  = cmd_i.div_step && (dcnt_q == DCW'(DivSteps - 1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HIT:  rd_addr = hit_q ? hit_idx_q : seg_idx_q;
      RD_NEXT: rd_addr = seg_idx_q + AW'(1);
      default: rd_addr = issue_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      pos_mem[wr_addr] <= pos_i;
      row_mem[wr_addr] <= vals_i;
    end
    pos_rd_q <= pos_mem[rd_addr];
    row_rd_q <= row_mem[rd_addr];
  end

  // table bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      varies_q <= '0;
    end else if (cmd_i.accept && op_i == OP_CLEAR) begin
      count_q  <= '0;
      varies_q <= '0;
    end else if (load_wr) begin
      count_q <= count_q + CW'(1);
      if (count_q != '0) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (vals_i[c*ValW +: ValW] != first_row_q[c*ValW +: ValW]) varies_q[c] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      last_row_q <= vals_i;
      last_pos_q <= pos_i;
      if (count_q == '0) begin
        first_row_q <= vals_i;
        first_pos_q <= pos_i;
      end
    end
    if (cmd_i.accept) begin
      x_q  <= pos_i;
      ch_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= '0;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      seg_q    <= 1'b0;
    end else if (cmd_i.scan_start) begin
      issue_q  <= '0;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      seg_q    <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rvalid_q <= (issue_q < count_q);
      if (issue_q < count_q) issue_q <= issue_q + CW'(1);
      if (hit_now && !hit_q) hit_q <= 1'b1;
      if (seg_now && !seg_q) seg_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run) begin
      ridx_q <= issue_q[AW-1:0];
      if (rvalid_q) prev_q <= pos_rd_q;
      if (hit_now && !hit_q) hit_idx_q <= ridx_q;
      if (seg_now && !seg_q) begin
        seg_idx_q <= ridx_q - AW'(1);
        t_q       <= x_q - prev_q;
        d_q       <= pos_rd_q - prev_q;
      end
    end
  end

  // difference, product and bit-serial division
  logic [ValW:0]     dv;
  logic [ValW-1:0]   v1;
  logic [2*ValW-1:0] prod;
  logic [ValW:0]     trial;
  assign v1    = pick(row_rd_q, ch_q);
  assign dv    = {v1[ValW-1], v1} - {v0_q[ValW-1], v0_q};
  assign prod  = mag_q * t_q;
  assign trial = {rem_q, quo_q[2*ValW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_v0) v0_q <= pick(row_rd_q, ch_q);
    if (cmd_i.cap_v1) begin
      neg_q <= dv[ValW];
      mag_q <= dv[ValW] ? ValW'(-dv) : dv[ValW-1:0];
    end
    if (cmd_i.mul) begin
      quo_q  <= prod;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCW'(1);
      if (trial >= {1'b0, d_q}) begin
        rem_q <= ValW'(trial - {1'b0, d_q});
        quo_q <= {quo_q[2*ValW-2:0], 1'b1};
      end else begin
        rem_q <= trial[ValW-1:0];
        quo_q <= {quo_q[2*ValW-2:0], 1'b0};
      end
    end
  end

  // result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_q    <= '0;
      res_st_q <= (op_i == OP_LOAD && full) ? ST_FULL : ST_OK;
    end else if (cmd_i.res_set) begin
      case (cmd_i.res_sel)
        RS_FIRST: begin
          res_q <= pick(first_row_q, ch_q); res_st_q <= ST_OK;
        end
        RS_LAST: begin
          res_q <= pick(last_row_q, ch_q); res_st_q <= ST_OK;
        end
        RS_ROW: begin
          res_q <= pick(row_rd_q, ch_q); res_st_q <= ST_OK;
        end
        RS_INTERP: begin
          res_q    <= neg_q ? v0_q - quo_q[ValW-1:0] : v0_q + quo_q[ValW-1:0];
          res_st_q <= ST_OK;
        end
        RS_NOSEG: begin
          res_q <= '0; res_st_q <= ST_NOSEG;
        end
        default: begin
          res_q <= '0; res_st_q <= ST_UNUSABLE;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_q;
      out_status_q <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond table size");
  a_strict_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_sel == RD_NEXT) |-> (t_q != '0 && t_q < d_q))
    else $error("interpolation segment does not strictly hold x");
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.div_done |=> (quo_q[2*ValW-1:ValW] == '0))
    else $error("quotient wider than a value");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !sts_o.out_busy)
    else $error("output register overwritten while held");

endmodule
`default_nettype wire
